### design/sfir_pkg.sv
package sfir_pkg;

    localparam int MAX_TAPS       = 63;
    localparam int COEF_FRAC_BITS = 15;

    localparam int SMP_W  = 16;
    localparam int PROD_W = 2 * SMP_W;
    localparam int CNT_W  = $clog2(MAX_TAPS + 1);
    localparam int ACC_W  = PROD_W + CNT_W + 1;
    localparam int CMP_W  = (CNT_W > 6) ? CNT_W : 6;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic CH_LEFT  = 1'b0;
    localparam logic CH_RIGHT = 1'b1;

    typedef logic signed [SMP_W-1:0] t_smp;

    // contents of one tap cell
    typedef struct packed {
        t_smp hl;
        t_smp hr;
        t_smp cl;
        t_smp cr;
    } t_tap;

    typedef struct packed {
        logic shift;
        logic rot;
        logic we_l;
        logic we_r;
    } t_cell_ctl;

    typedef struct packed {
        logic clr;
        logic en;
    } t_mac_ctl;

endpackage

### design/sfir_cell.sv
module sfir_cell
    import sfir_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_smp      i_coef,
    input  t_tap      i_prev,
    input  t_tap      i_next,
    output t_tap      o_tap
);

    t_smp r_hl, r_hr, r_cl, r_cr;

    // history: shift from previous cell on a new item, rotate from next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hl <= '0;
            r_hr <= '0;
        end else if (i_ctl.shift) begin
            r_hl <= i_prev.hl;
            r_hr <= i_prev.hr;
        end else if (i_ctl.rot) begin
            r_hl <= i_next.hl;
            r_hr <= i_next.hr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rot) begin
            r_cl <= i_next.cl;
            r_cr <= i_next.cr;
        end else begin
            if (i_ctl.we_l) begin
                r_cl <= i_coef;
            end
            if (i_ctl.we_r) begin
                r_cr <= i_coef;
            end
        end
    end

    assign o_tap = '{hl: r_hl, hr: r_hr, cl: r_cl, cr: r_cr};

endmodule

### design/sfir_mac.sv
module sfir_mac
    import sfir_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mac_ctl i_ctl,
    input  t_smp     i_coef,
    input  t_smp     i_hist,
    output t_smp     o_y
);

    localparam logic [ACC_W-1:0] RND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
    localparam logic [ACC_W-1:0] POS_MAX  = ACC_W'(32767);
    localparam logic [ACC_W-1:0] NEG_MAG  = ACC_W'(32768);

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_pv;
    logic signed [ACC_W-1:0]  r_acc;

    logic [ACC_W-1:0] w_mag;
    logic [ACC_W-1:0] w_rnd;

    always_ff @(posedge i_clk) begin
        r_prod <= i_coef * i_hist;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (i_ctl.clr) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_ctl.en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (r_pv) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // round half away from zero, then saturate
    always_comb begin
        w_mag = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
        w_rnd = (w_mag + RND_HALF) >> COEF_FRAC_BITS;
        if (r_acc[ACC_W-1]) begin
            if (w_rnd > NEG_MAG) begin
                o_y = 16'sh8000;
            end else begin
                o_y = SMP_W'(-w_rnd);
            end
        end else begin
            if (w_rnd > POS_MAX) begin
                o_y = 16'sh7fff;
            end else begin
                o_y = w_rnd[SMP_W-1:0];
            end
        end
    end

endmodule

### design/stereo_fir_filter_core.sv
// channel   dir  handshake                  content
// s_axis    in   s_axis_tvalid/tready       load item or stereo sample item
// m_axis    out  m_axis_tvalid/tready       filtered stereo pair
// cfg       in   i_cfg_we                   half order
//
// A sample item rotates the tap ring once past one shared multiply-accumulate
// per channel, then passes a drain step (ST_TAIL) and a round step (ST_DONE).
// A load item leaves the core idle. Synchronous reset clears delay lines and control.
// A finished pair waits in the output register; the next item is accepted meanwhile,
// and a result stalls in the round step only while the previous one is still pending.
module stereo_fir_filter_core
    import sfir_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // coef_index[5:0], coef_value[21:6], left_in[37:22], right_in[53:38], zero pad
    input  logic [55:0] s_axis_tdata,
    // op[0], coef_channel[1]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // left_out[15:0], right_out[31:16]
    output logic [31:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_TAIL = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_TAPS - 1);
    localparam logic [CMP_W-1:0] TAPS_MAX = CMP_W'(MAX_TAPS);

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [4:0]       r_half_order;
    logic             r_out_valid, n_out_valid;
    t_smp             r_out_l, r_out_r;

    logic             w_in_acc;
    logic             w_smp_acc;
    logic             w_load_acc;
    logic             w_out_free;
    logic [CMP_W-1:0] w_taps_raw;
    logic [CMP_W-1:0] w_taps;
    logic             w_rot;
    t_tap             w_tap [MAX_TAPS];
    t_tap             w_head;
    t_mac_ctl         w_mac_ctl;
    t_smp             w_y_l, w_y_r;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_smp_acc     = w_in_acc && (s_axis_tuser[0] == OP_SAMPLE);
    assign w_load_acc    = w_in_acc && (s_axis_tuser[0] == OP_LOAD);
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_rot         = (r_state == ST_RUN);

    assign w_taps_raw = CMP_W'({r_half_order, 1'b1});
    assign w_taps     = (w_taps_raw > TAPS_MAX) ? TAPS_MAX : w_taps_raw;

    assign w_head = '{hl: s_axis_tdata[37:22], hr: s_axis_tdata[53:38], cl: '0, cr: '0};

    genvar gi;
    generate
        for (gi = 0; gi < MAX_TAPS; gi++) begin : g_cell
            localparam int NXT = (gi + 1) % MAX_TAPS;
            t_cell_ctl w_ctl;
            t_tap      w_prev;
            logic      w_hit;

            assign w_hit  = (CMP_W'(s_axis_tdata[5:0]) == CMP_W'(gi));
            assign w_ctl  = '{shift: w_smp_acc,
                              rot:   w_rot,
                              we_l:  w_load_acc && w_hit && (s_axis_tuser[1] == CH_LEFT),
                              we_r:  w_load_acc && w_hit && (s_axis_tuser[1] == CH_RIGHT)};
            if (gi == 0) begin : g_head
                assign w_prev = w_head;
            end else begin : g_body
                assign w_prev = w_tap[gi-1];
            end

            sfir_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_coef  (s_axis_tdata[21:6]),
                .i_prev  (w_prev),
                .i_next  (w_tap[NXT]),
                .o_tap   (w_tap[gi])
            );
        end
    endgenerate

    assign w_mac_ctl = '{clr: w_smp_acc,
                         en:  w_rot && (CMP_W'(r_cnt) < w_taps)};

    sfir_mac u_mac_l (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_coef  (w_tap[0].cl),
        .i_hist  (w_tap[0].hl),
        .o_y     (w_y_l)
    );

    sfir_mac u_mac_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_coef  (w_tap[0].cr),
        .i_hist  (w_tap[0].hr),
        .o_y     (w_y_r)
    );

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (w_smp_acc) begin
                    n_state = ST_RUN;
                    n_cnt   = '0;
                end
            end
            ST_RUN: begin
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_TAIL;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_TAIL: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
            r_half_order <= 5'd31;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_half_order <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DONE) && w_out_free) begin
            r_out_l <= w_y_l;
            r_out_r <= w_y_r;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_r, r_out_l};

    a_smp_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_smp_acc |=> (r_state == ST_RUN) && (r_cnt == '0))
        else $error("sample item did not start the tap sweep");

    a_load_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_acc |=> (r_state == ST_IDLE))
        else $error("load item left idle");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (CMP_W'(r_cnt) < TAPS_MAX))
        else $error("tap counter out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> r_out_valid && $stable(r_out_l)
            && $stable(r_out_r))
        else $error("pending result overwritten");

endmodule
